FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the slot tracker RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, cond)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/mst_pkg.sv
// ----------------------------------------------------------------------------
// mst_pkg
// Types and constants for the multitouch slot tracker.
// ----------------------------------------------------------------------------
package mst_pkg;

    localparam int SLOTS   = 16;
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [1:0] MODE_EVENT     = 2'd0;
    localparam logic [1:0] MODE_REV_SEL   = 2'd1;
    localparam logic [1:0] MODE_REV_PHASE = 2'd2;
    localparam logic [1:0] MODE_REV_CLEAR = 2'd3;

    localparam logic [5:0] EV_SLOT         = 6'd47;
    localparam logic [5:0] EV_TOUCH_MAJOR  = 6'd48;
    localparam logic [5:0] EV_WIDTH_MAJOR  = 6'd50;
    localparam logic [5:0] EV_POS_X        = 6'd53;
    localparam logic [5:0] EV_POS_Y        = 6'd54;
    localparam logic [5:0] EV_TRACK        = 6'd57;
    localparam logic [5:0] EV_PRESSURE     = 6'd58;

    localparam logic [1:0] PH_INACTIVE = 2'd0;
    localparam logic [1:0] PH_BEGIN    = 2'd1;
    localparam logic [1:0] PH_UPDATE   = 2'd2;
    localparam logic [1:0] PH_END      = 2'd3;

    localparam logic [31:0] NO_TRACK = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]         mode;
        logic [5:0]         code;
        logic signed [31:0] value;
    } item_t;

    typedef struct packed {
        logic               handled;
        logic [3:0]         slot_index;
        logic [1:0]         slot_state;
        logic signed [31:0] contact_id;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] major_touch;
        logic signed [31:0] major_width;
        logic signed [31:0] press_level;
        logic [4:0]         active_total;
        logic               review_active;
    } result_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_SLOT,
        OP_TRACK,
        OP_POS_X,
        OP_POS_Y,
        OP_TOUCH,
        OP_WIDTH,
        OP_PRESS,
        OP_REV_SEL,
        OP_REV_PHASE,
        OP_REV_CLEAR
    } op_t;

    // classified command handed from the front end to the back end
    typedef struct packed {
        op_t         op;
        logic        idx_ok;
        logic        phase_ok;
        logic        no_track;
        logic [31:0] value;
    } cmd_t;

endpackage

FILE: rtl/mst_front.sv
// ----------------------------------------------------------------------------
// mst_front
// Accepts input words, decodes them into commands and queues them.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mst_front
    import mst_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    output logic  full,
    input  item_t item,
    output logic  cmd_valid,
    input  logic  cmd_take,
    output cmd_t  cmd
);

    function automatic cmd_t classify(input item_t it);
        cmd_t c;
        c.value    = it.value;
        c.idx_ok   = !it.value[31] && (it.value < 32'(SLOTS));
        c.phase_ok = (it.value[31:2] == 30'd0);
        c.no_track = (it.value == NO_TRACK);
        c.op       = OP_NOP;
        unique case (it.mode)
            MODE_EVENT:
            begin
                unique case (it.code)
                    EV_SLOT:        c.op = OP_SLOT;
                    EV_TRACK:       c.op = OP_TRACK;
                    EV_POS_X:       c.op = OP_POS_X;
                    EV_POS_Y:       c.op = OP_POS_Y;
                    EV_TOUCH_MAJOR: c.op = OP_TOUCH;
                    EV_WIDTH_MAJOR: c.op = OP_WIDTH;
                    EV_PRESSURE:    c.op = OP_PRESS;
                    default:        c.op = OP_NOP;
                endcase
            end
            MODE_REV_SEL:   c.op = OP_REV_SEL;
            MODE_REV_PHASE: c.op = OP_REV_PHASE;
            MODE_REV_CLEAR: c.op = OP_REV_CLEAR;
            default:        c.op = OP_NOP;
        endcase
        return c;
    endfunction

    cmd_t               q_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;
    logic               do_push;
    logic               do_pop;

    assign full      = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_take && cmd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= classify(item);
        end
    end

    `ASSERT_ALWAYS(a_cnt_bound, clk, rst_n, cnt_reg <= Q_CNT_W'(Q_DEPTH))
    `ASSERT_IMPLIES(a_take_nonempty, clk, rst_n, cmd_take, cnt_reg != '0)
    `ASSERT_NEXT(a_push_counts, clk, rst_n, do_push && !do_pop, cnt_reg == $past(cnt_reg) + 1'b1)

endmodule

FILE: rtl/mst_back.sv
// ----------------------------------------------------------------------------
// mst_back
// Executes commands against the slot table and holds the result word.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mst_back
    import mst_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_valid,
    output logic    cmd_take,
    input  cmd_t    cmd,
    output logic    empty,
    input  logic    pop,
    output result_t result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ
    } state_t;

    state_t            state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic              handled_reg, handled_next;
    logic [SLOT_W-1:0] cur_reg, cur_next;
    logic [SLOT_W-1:0] rev_reg, rev_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [SLOTS-1:0]  act_reg, act_next;
    logic [1:0]        phase_reg [SLOTS];
    logic [1:0]        phase_next [SLOTS];
    logic [31:0]       track_reg [SLOTS];
    logic [31:0]       track_next [SLOTS];
    logic [31:0]       x_reg [SLOTS];
    logic [31:0]       x_next [SLOTS];
    logic [31:0]       y_reg [SLOTS];
    logic [31:0]       y_next [SLOTS];
    logic [31:0]       touch_reg [SLOTS];
    logic [31:0]       touch_next [SLOTS];
    logic [31:0]       width_reg [SLOTS];
    logic [31:0]       width_next [SLOTS];
    logic [31:0]       press_reg [SLOTS];
    logic [31:0]       press_next [SLOTS];
    result_t           res_reg, res_next;
    logic              res_valid_reg, res_valid_next;

    logic              is_rev;
    logic [SLOT_W-1:0] tgt;
    logic [SLOT_W-1:0] sel;
    logic [SLOT_W-1:0] trk_addr;
    logic [31:0]       trk_rd;
    logic              ph_wr;
    logic [1:0]        ph_val;
    logic              can_load;

    assign is_rev = (cmd_reg.op == OP_REV_SEL) || (cmd_reg.op == OP_REV_PHASE)
                 || (cmd_reg.op == OP_REV_CLEAR);
    assign tgt    = is_rev ? rev_reg : cur_reg;
    assign sel    = is_rev ? rev_reg : cur_reg;
    // one read port on the id column: compare during execute, report during read-out
    assign trk_addr = (state_reg == S_EXEC) ? tgt : sel;
    assign trk_rd   = track_reg[trk_addr];
    assign can_load = !res_valid_reg || pop;

    assign empty  = !res_valid_reg;
    assign result = res_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        handled_next   = handled_reg;
        cur_next       = cur_reg;
        rev_next       = rev_reg;
        cnt_next       = cnt_reg;
        act_next       = act_reg;
        phase_next     = phase_reg;
        track_next     = track_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        touch_next     = touch_reg;
        width_next     = width_reg;
        press_next     = press_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !pop;
        cmd_take       = 1'b0;
        ph_wr          = 1'b0;
        ph_val         = PH_INACTIVE;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_take   = 1'b1;
                    cmd_next   = cmd;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                handled_next = 1'b1;
                case (cmd_reg.op)
                    OP_SLOT:
                    begin
                        if (cmd_reg.idx_ok)
                        begin
                            cur_next = cmd_reg.value[SLOT_W-1:0];
                        end
                    end
                    OP_TRACK:
                    begin
                        ph_wr = 1'b1;
                        if (cmd_reg.no_track)
                        begin
                            // old id kept so a returning id counts as an update
                            ph_val = PH_END;
                        end
                        else
                        begin
                            ph_val = (trk_rd != cmd_reg.value) ? PH_BEGIN : PH_UPDATE;
                            track_next[tgt] = cmd_reg.value;
                        end
                    end
                    OP_POS_X: x_next[tgt]     = cmd_reg.value;
                    OP_POS_Y: y_next[tgt]     = cmd_reg.value;
                    OP_TOUCH: touch_next[tgt] = cmd_reg.value;
                    OP_WIDTH: width_next[tgt] = cmd_reg.value;
                    OP_PRESS: press_next[tgt] = cmd_reg.value;
                    OP_REV_SEL:
                    begin
                        handled_next = cmd_reg.idx_ok;
                        if (cmd_reg.idx_ok)
                        begin
                            rev_next = cmd_reg.value[SLOT_W-1:0];
                        end
                    end
                    OP_REV_PHASE:
                    begin
                        handled_next = cmd_reg.phase_ok;
                        ph_wr        = cmd_reg.phase_ok;
                        ph_val       = cmd_reg.value[1:0];
                    end
                    OP_REV_CLEAR:
                    begin
                        ph_wr           = 1'b1;
                        ph_val          = PH_INACTIVE;
                        track_next[tgt] = NO_TRACK;
                    end
                    default: handled_next = 1'b0;
                endcase

                if (ph_wr)
                begin
                    if (act_reg[tgt] && (ph_val == PH_INACTIVE))
                    begin
                        cnt_next = cnt_reg - 1'b1;
                    end
                    else if (!act_reg[tgt] && (ph_val != PH_INACTIVE))
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                    act_next[tgt]   = (ph_val != PH_INACTIVE);
                    phase_next[tgt] = ph_val;
                end
                state_next = S_READ;
            end
            S_READ:
            begin
                if (can_load)
                begin
                    res_next.handled       = handled_reg;
                    res_next.slot_index    = 4'(sel);
                    res_next.slot_state    = phase_reg[sel];
                    res_next.contact_id    = trk_rd;
                    res_next.pos_x         = x_reg[sel];
                    res_next.pos_y         = y_reg[sel];
                    res_next.major_touch   = touch_reg[sel];
                    res_next.major_width   = width_reg[sel];
                    res_next.press_level   = press_reg[sel];
                    res_next.active_total  = 5'(cnt_reg);
                    res_next.review_active = act_reg[rev_reg];
                    res_valid_next         = 1'b1;
                    if (cmd_valid)
                    begin
                        cmd_take   = 1'b1;
                        cmd_next   = cmd;
                        state_next = S_EXEC;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
            cur_reg       <= '0;
            rev_reg       <= '0;
            cnt_reg       <= '0;
            act_reg       <= '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                phase_reg[i] <= PH_INACTIVE;
                track_reg[i] <= NO_TRACK;
                x_reg[i]     <= '0;
                y_reg[i]     <= '0;
                touch_reg[i] <= '0;
                width_reg[i] <= '0;
                press_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            cur_reg       <= cur_next;
            rev_reg       <= rev_next;
            cnt_reg       <= cnt_next;
            act_reg       <= act_next;
            phase_reg     <= phase_next;
            track_reg     <= track_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            touch_reg     <= touch_next;
            width_reg     <= width_next;
            press_reg     <= press_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        handled_reg <= handled_next;
        res_reg     <= res_next;
    end

    `ASSERT_ALWAYS(a_cnt_matches, clk, rst_n, cnt_reg == CNT_W'($countones(act_reg)))
    `ASSERT_NEXT(a_exec_to_read, clk, rst_n, state_reg == S_EXEC, state_reg == S_READ)
    `ASSERT_ALWAYS(a_cur_range, clk, rst_n, 32'(cur_reg) < 32'(SLOTS))
    `ASSERT_IMPLIES(a_take_state, clk, rst_n, cmd_take, state_reg != S_EXEC)

endmodule

FILE: rtl/multitouch_slot_tracker_top.sv
// Multitouch slot tracker. Input words enter a two-word command queue and are
// decoded there; the execute engine then handles each word in state S_EXEC,
// to update the slot table, and then in state S_READ, to read the reported
// slot into the result register, taking the next word as it loads a result.
// It stalls in S_READ while an unpopped result is held; a result waits in the
// result register while the queue keeps taking words until it is full.
// ----------------------------------------------------------------------------
// multitouch_slot_tracker_top
// Queue-style wrapper joining the decode front end and the slot table engine.
// ----------------------------------------------------------------------------
module multitouch_slot_tracker_top
    import mst_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    output logic    full,
    input  item_t   item,
    output logic    empty,
    input  logic    pop,
    output result_t result
);

    logic cmd_valid;
    logic cmd_take;
    cmd_t cmd;

    mst_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd       (cmd)
    );

    mst_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd       (cmd),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule
